>>> sv/vertex_rotate_translate_top_assert.svh
// assertion macros used by the vertex transform top
`ifndef VERTEX_ROTATE_TRANSLATE_TOP_ASSERT_SVH
`define VERTEX_ROTATE_TRANSLATE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VRT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vrt assertion failed");

// next-cycle implication, checked outside reset
`define VRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vrt assertion failed");

`endif

>>> sv/vrt_pkg.sv
// shared types, constants and helpers for the vertex transform pipeline
package vrt_pkg;

  localparam int COEF_W  = 16;
  localparam int TRANS_W = 16;
  localparam int ROW_W   = 3 * COEF_W;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 6;
  localparam int IDX_W   = 3;

  localparam int XY_SCALE = 11;
  localparam int Z_SCALE  = 9;
  localparam int Z_BIAS   = 3 << 12;

  localparam int ROW_SHIFT [3] = '{14, 14, 16};

  localparam logic [IDX_W-1:0] REG_ROW_ZERO = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW_ONE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW_TWO  = 3'd2;
  localparam logic [IDX_W-1:0] REG_TRANS_X  = 3'd3;
  localparam logic [IDX_W-1:0] REG_TRANS_Y  = 3'd4;
  localparam logic [IDX_W-1:0] REG_TRANS_Z  = 3'd5;

  typedef struct packed {
    logic load;
    logic valid_in;
  } stage_ctrl_t;

  // coefficient j of a packed row, lowest word first
  function automatic logic signed [COEF_W-1:0] coef(input logic [ROW_W-1:0] row,
                                                    input int j);
    coef = $signed(row[j*COEF_W +: COEF_W]);
  endfunction

endpackage

>>> sv/vrt_cfg.sv
// apb register file holding the matrix rows and the translation
module vrt_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vrt_pkg::ADDR_W-1:0]        paddr,
  input  logic [vrt_pkg::DATA_W-1:0]        pwdata,
  output logic [vrt_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  output logic [vrt_pkg::ROW_W-1:0]         rows [3],
  output logic signed [vrt_pkg::TRANS_W-1:0] trans [3]
);

  logic [vrt_pkg::IDX_W-1:0] idx;
  logic                      wr;

  assign idx    = paddr[vrt_pkg::ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        rows[i]  <= '0;
        trans[i] <= '0;
      end
    end else if (wr) begin
      case (idx)
        vrt_pkg::REG_ROW_ZERO: rows[0]  <= pwdata[vrt_pkg::ROW_W-1:0];
        vrt_pkg::REG_ROW_ONE:  rows[1]  <= pwdata[vrt_pkg::ROW_W-1:0];
        vrt_pkg::REG_ROW_TWO:  rows[2]  <= pwdata[vrt_pkg::ROW_W-1:0];
        vrt_pkg::REG_TRANS_X:  trans[0] <= $signed(pwdata[vrt_pkg::TRANS_W-1:0]);
        vrt_pkg::REG_TRANS_Y:  trans[1] <= $signed(pwdata[vrt_pkg::TRANS_W-1:0]);
        vrt_pkg::REG_TRANS_Z:  trans[2] <= $signed(pwdata[vrt_pkg::TRANS_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      vrt_pkg::REG_ROW_ZERO: prdata = vrt_pkg::DATA_W'(rows[0]);
      vrt_pkg::REG_ROW_ONE:  prdata = vrt_pkg::DATA_W'(rows[1]);
      vrt_pkg::REG_ROW_TWO:  prdata = vrt_pkg::DATA_W'(rows[2]);
      vrt_pkg::REG_TRANS_X:  prdata = vrt_pkg::DATA_W'(unsigned'(trans[0]));
      vrt_pkg::REG_TRANS_Y:  prdata = vrt_pkg::DATA_W'(unsigned'(trans[1]));
      vrt_pkg::REG_TRANS_Z:  prdata = vrt_pkg::DATA_W'(unsigned'(trans[2]));
      default:               prdata = '0;
    endcase
  end

endmodule

>>> sv/vrt_mult.sv
// first stage: the nine coordinate by coefficient products
module vrt_mult #(
  parameter int COORD_WIDTH = 16,
  parameter int PROD_W      = COORD_WIDTH + vrt_pkg::COEF_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  vrt_pkg::stage_ctrl_t           ctrl,
  input  logic signed [COORD_WIDTH-1:0]  coord [3],
  input  logic [vrt_pkg::ROW_W-1:0]      rows [3],
  output logic                           valid,
  output logic signed [PROD_W-1:0]       prod [3][3]
);

  logic signed [PROD_W-1:0] prod_next [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_next[i][j] = PROD_W'(coord[j]) * PROD_W'(vrt_pkg::coef(rows[i], j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= ctrl.valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod <= prod_next;
    end
  end

endmodule

>>> sv/vrt_sum.sv
// second stage: row sums, z term weighted by four
module vrt_sum #(
  parameter int COORD_WIDTH = 16,
  parameter int PROD_W      = COORD_WIDTH + vrt_pkg::COEF_W,
  parameter int SUM_W       = COORD_WIDTH + 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  vrt_pkg::stage_ctrl_t      ctrl,
  input  logic signed [PROD_W-1:0]  prod [3][3],
  output logic                      valid,
  output logic signed [SUM_W-1:0]   sum [3]
);

  logic signed [SUM_W-1:0] sum_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_next[i] = SUM_W'(prod[i][0]) + SUM_W'(prod[i][1])
                  + (SUM_W'(prod[i][2]) <<< 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= ctrl.valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sum <= sum_next;
    end
  end

endmodule

>>> sv/vrt_out.sv
// third stage: scale down, add translation, wrap into the output register
module vrt_out #(
  parameter int COORD_WIDTH = 16,
  parameter int SUM_W       = COORD_WIDTH + 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  vrt_pkg::stage_ctrl_t               ctrl,
  input  logic signed [SUM_W-1:0]            sum [3],
  input  logic signed [vrt_pkg::TRANS_W-1:0] trans [3],
  output logic                               valid,
  output logic signed [COORD_WIDTH-1:0]      res [3]
);

  logic signed [SUM_W-1:0] offset [3];
  logic signed [SUM_W-1:0] total  [3];

  always_comb begin
    offset[0] = SUM_W'(trans[0]) <<< vrt_pkg::XY_SCALE;
    offset[1] = SUM_W'(trans[1]) <<< vrt_pkg::XY_SCALE;
    offset[2] = (SUM_W'(trans[2]) <<< vrt_pkg::Z_SCALE) - SUM_W'(vrt_pkg::Z_BIAS);
    for (int i = 0; i < 3; i++) begin
      total[i] = (sum[i] >>> vrt_pkg::ROW_SHIFT[i]) + offset[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= ctrl.valid_in;
    end
  end

  // only the low bits survive, so the result wraps
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < 3; i++) begin
        res[i] <= total[i][COORD_WIDTH-1:0];
      end
    end
  end

endmodule

>>> sv/vertex_rotate_translate_top.sv
// vertex transform top: fixed-point 3x3 rotation plus translation, three-stage pipe
// an accepted input beat passes the product, sum and scale registers in turn to reach out_valid
// throughput: one vertex per cycle; each stage holds only while the one after is blocked
// in_stall rises only when all three stages are full and out_stall is high
// reset clears the stage valid bits and all config registers to zero
`include "vertex_rotate_translate_top_assert.svh"
module vertex_rotate_translate_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vrt_pkg::ADDR_W-1:0]        paddr,
  input  logic [vrt_pkg::DATA_W-1:0]        pwdata,
  output logic [vrt_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     coord_x,
  input  logic signed [COORD_WIDTH-1:0]     coord_y,
  input  logic signed [COORD_WIDTH-1:0]     coord_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COORD_WIDTH-1:0]     out_x,
  output logic signed [COORD_WIDTH-1:0]     out_y,
  output logic signed [COORD_WIDTH-1:0]     out_z
);

  localparam int PROD_W = COORD_WIDTH + vrt_pkg::COEF_W;
  localparam int SUM_W  = COORD_WIDTH + 20;

  logic [vrt_pkg::ROW_W-1:0]         rows  [3];
  logic signed [vrt_pkg::TRANS_W-1:0] trans [3];
  logic signed [COORD_WIDTH-1:0]     coord [3];
  logic signed [PROD_W-1:0]          prod  [3][3];
  logic signed [SUM_W-1:0]           sum   [3];
  logic signed [COORD_WIDTH-1:0]     res   [3];

  logic v1, v2;
  logic en1, en2, en3;
  vrt_pkg::stage_ctrl_t ctrl1, ctrl2, ctrl3;

  // a stage loads when it is empty or the stage after it moves
  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  assign ctrl1 = '{load: en1, valid_in: in_valid};
  assign ctrl2 = '{load: en2, valid_in: v1};
  assign ctrl3 = '{load: en3, valid_in: v2};

  assign coord[0] = coord_x;
  assign coord[1] = coord_y;
  assign coord[2] = coord_z;

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];

  vrt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rows    (rows),
    .trans   (trans)
  );

  vrt_mult #(.COORD_WIDTH(COORD_WIDTH), .PROD_W(PROD_W)) u_mult (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl1),
    .coord (coord),
    .rows  (rows),
    .valid (v1),
    .prod  (prod)
  );

  vrt_sum #(.COORD_WIDTH(COORD_WIDTH), .PROD_W(PROD_W), .SUM_W(SUM_W)) u_sum (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl2),
    .prod  (prod),
    .valid (v2),
    .sum   (sum)
  );

  vrt_out #(.COORD_WIDTH(COORD_WIDTH), .SUM_W(SUM_W)) u_out (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl3),
    .sum   (sum),
    .trans (trans),
    .valid (out_valid),
    .res   (res)
  );

  // input backs up only behind a completely full pipe
  `VRT_ASSERT_IMPL(a_stall_only_full, in_stall, v1 && v2 && out_valid && out_stall)
  // a blocked first stage keeps its beat
  `VRT_ASSERT_NEXT(a_first_stage_holds, v1 && !en2, v1)
  // a taken result with nothing behind it empties the output
  `VRT_ASSERT_NEXT(a_output_drains, out_valid && !out_stall && !v2, !out_valid)

endmodule
